[design/pfe_pkg.sv]
// Shared types, codes and the per-entry step function of the palette fade engine.
// Used by pfe_ctrl, pfe_datapath and palette_fade_engine; depends on nothing.
package pfe_pkg;

	localparam int ENTRIES_DEF    = 64;
	localparam int FADE_TICKS_DEF = 22;
	localparam int LEVEL_STEP_DEF = 32;

	localparam logic [7:0] WHITE_LEVEL = 8'd224;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 2;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	typedef enum logic [1:0] {
		FUNC_WRITE,
		FUNC_READ,
		FUNC_START,
		FUNC_TICK
	} func_t;

	typedef enum logic [1:0] {
		KIND_FADE_IN,
		KIND_FADE_OUT,
		KIND_FLASH_IN,
		KIND_FLASH_OUT
	} kind_t;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_FADE_IN,
		MODE_FADE_OUT,
		MODE_FLASH_IN,
		MODE_FLASH_OUT
	} mode_t;

	typedef enum logic [1:0] {
		BANK_WORK1,
		BANK_TARGET1,
		BANK_WORK2,
		BANK_TARGET2
	} bank_t;

	typedef enum logic [1:0] {
		CFG_FIRST_ENTRY,
		CFG_ENTRY_SPAN,
		CFG_PAIR_TWO
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_STEP,
		ST_RESULT
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;
		logic step_rd;
		logic fill_wr;
		logic pass;
		logic out_load;
	} pfe_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		mode_t      mode;
		logic [5:0] first_entry;
		logic [5:0] entry_span;
		logic       pair_en;
	} pfe_status_t;

	// Moves one channel of a working entry by one step, in the order of the mode.
	function automatic rgb_t step_rgb(input mode_t mode, input rgb_t d, input rgb_t t,
			input logic [7:0] stp);
		rgb_t n;
		n = d;
		case (mode)
			MODE_FADE_IN: begin
				if (t.b > d.b) n.b = d.b + stp;
				else if (t.g > d.g) n.g = d.g + stp;
				else if (t.r > d.r) n.r = d.r + stp;
			end
			MODE_FADE_OUT: begin
				if (d.r != 8'd0) n.r = d.r - stp;
				else if (d.g != 8'd0) n.g = d.g - stp;
				else if (d.b != 8'd0) n.b = d.b - stp;
			end
			MODE_FLASH_IN: begin
				if (t.b < d.b) n.b = d.b - stp;
				else if (t.g < d.g) n.g = d.g - stp;
				else if (t.r < d.r) n.r = d.r - stp;
			end
			MODE_FLASH_OUT: begin
				if (d.r != WHITE_LEVEL) n.r = d.r + stp;
				else if (d.g != WHITE_LEVEL) n.g = d.g + stp;
				else if (d.b != WHITE_LEVEL) n.b = d.b + stp;
			end
			default: begin
				n = d;
			end
		endcase
		return n;
	endfunction

endpackage

[design/pfe_datapath.sv]
// Datapath of the palette fade engine: palette memory, step unit, mode, tick count,
// configuration registers and the output register. Depends on pfe_pkg.
module pfe_datapath import pfe_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int FADE_TICKS = FADE_TICKS_DEF,
	parameter int LEVEL_STEP = LEVEL_STEP_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pfe_cmd_t                   cmd,
	input  logic [$clog2(ENTRIES)-1:0] ptr,
	output pfe_status_t                status,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]      cfg_data,
	input  func_t                      func,
	input  bank_t                      bank,
	input  logic [5:0]                 entry_index,
	input  logic [7:0]                 red_in,
	input  logic [7:0]                 green_in,
	input  logic [7:0]                 blue_in,
	input  kind_t                      fade_kind,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = (IW + 1 > 7) ? IW + 1 : 7;
	localparam int AW = IW + 2;
	localparam int TW = $clog2(FADE_TICKS + 1);
	localparam int DEPTH = 4 << IW;
	localparam logic [CW-1:0] ENTRIES_W = CW'(ENTRIES);
	localparam logic [7:0] LSTEP = 8'(LEVEL_STEP);
	localparam logic [TW-1:0] TICKS_W = TW'(FADE_TICKS);

	rgb_t          mem [DEPTH];
	rgb_t          rd_a_q;
	rgb_t          rd_b_q;
	logic          step_vld_s1;
	logic [AW-1:0] waddr_s1;

	mode_t           mode_q;
	logic [TW-1:0]   count_q;
	logic [5:0]      first_q;
	logic [5:0]      span_q;
	logic            pair_q;
	logic            done_q;
	func_t           func_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic [CW-1:0] idx_w;
	logic [IW-1:0] idx;
	bank_t         work_bank;
	bank_t         tgt_bank;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;
	logic          rd_en;
	logic          we;
	logic [AW-1:0] waddr;
	rgb_t          wdata;
	rgb_t          fill_val;
	logic [TW-1:0] count_inc;
	logic          tick_hit;
	rgb_t          rd_res;

	always_comb begin
		idx_w = CW'(entry_index);
		for (int k = 0; k < 4; k++) begin
			if (idx_w >= ENTRIES_W) idx_w = idx_w - ENTRIES_W;
		end
	end
	assign idx = idx_w[IW-1:0];

	assign work_bank = cmd.pass ? BANK_WORK2 : BANK_WORK1;
	assign tgt_bank  = cmd.pass ? BANK_TARGET2 : BANK_TARGET1;
	assign raddr_a   = cmd.take ? {bank, idx} : {work_bank, ptr};
	assign raddr_b   = {tgt_bank, ptr};
	assign rd_en     = (cmd.take && func == FUNC_READ) || cmd.step_rd;

	assign fill_val = (mode_q == MODE_FADE_IN) ? rgb_t'(24'd0) :
		'{r: WHITE_LEVEL, g: WHITE_LEVEL, b: WHITE_LEVEL};

	always_comb begin
		we    = 1'b0;
		waddr = raddr_a;
		wdata = '{r: red_in, g: green_in, b: blue_in};
		if (step_vld_s1) begin
			we    = 1'b1;
			waddr = waddr_s1;
			wdata = step_rgb(mode_q, rd_a_q, rd_b_q, LSTEP);
		end else if (cmd.fill_wr) begin
			we    = 1'b1;
			waddr = {BANK_WORK1, ptr};
			wdata = fill_val;
		end else if (cmd.take && func == FUNC_WRITE) begin
			we    = 1'b1;
			waddr = {bank, idx};
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (rd_en) begin
			rd_a_q <= mem[raddr_a];
			rd_b_q <= mem[raddr_b];
		end
		waddr_s1 <= {work_bank, ptr};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_vld_s1 <= 1'b0;
		end else begin
			step_vld_s1 <= cmd.step_rd;
		end
	end

	assign count_inc = count_q + TW'(1);
	assign tick_hit  = count_inc >= TICKS_W;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			count_q <= '0;
			first_q <= 6'd0;
			span_q  <= 6'd63;
			pair_q  <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FIRST_ENTRY: first_q <= cfg_data;
					CFG_ENTRY_SPAN:  span_q  <= cfg_data;
					CFG_PAIR_TWO:    pair_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end
			if (cmd.take) begin
				case (func)
					FUNC_START: begin
						mode_q  <= mode_t'({1'b0, fade_kind} + 3'd1);
						count_q <= '0;
					end
					FUNC_TICK: begin
						if (mode_q != MODE_NONE) count_q <= tick_hit ? '0 : count_inc;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q <= func;
			case (func)
				FUNC_START: done_q <= 1'b0;
				FUNC_TICK:  done_q <= (mode_q == MODE_NONE) || tick_hit;
				default:    done_q <= (mode_q == MODE_NONE);
			endcase
		end
		if (cmd.out_load) begin
			m_data_q <= {6'd0, rd_res.b, rd_res.g, rd_res.r, mode_q != MODE_NONE, done_q};
		end
	end

	assign rd_res  = (func_q == FUNC_READ) ? rd_a_q : rgb_t'(24'd0);
	assign m_tdata = m_data_q;

	assign status.mode        = mode_q;
	assign status.first_entry = first_q;
	assign status.entry_span  = span_q;
	assign status.pair_en     = pair_q;

endmodule

[design/pfe_ctrl.sv]
// Controller of the palette fade engine: item decode, sweep and step sequencing,
// entry range and output handshake. Depends on pfe_pkg.
module pfe_ctrl import pfe_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	input  func_t                      func,
	input  kind_t                      fade_kind,
	input  pfe_status_t                status,
	output pfe_cmd_t                   cmd,
	output logic [$clog2(ENTRIES)-1:0] ptr
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = (IW + 1 > 7) ? IW + 1 : 7;
	localparam logic [CW-1:0] ENTRIES_W = CW'(ENTRIES);

	ctrl_state_t   state_q, state_n;
	logic [CW-1:0] ptr_q, ptr_n;
	logic [CW-1:0] lo_q, lo_n;
	logic [CW-1:0] hi_q, hi_n;
	logic          pass_q, pass_n;
	logic          pair_q, pair_n;
	logic          m_valid_q, m_valid_n;

	logic [CW-1:0] first_w;
	logic [CW-1:0] end_w;
	logic          fin_empty;
	logic [CW-1:0] fin_hi;
	logic [CW-1:0] ptr_inc;
	logic          out_free;
	logic          in_mode;

	assign first_w   = CW'(status.first_entry);
	assign end_w     = first_w + CW'(status.entry_span);
	assign fin_empty = first_w >= ENTRIES_W;
	assign fin_hi    = (end_w >= ENTRIES_W) ? ENTRIES_W : end_w + CW'(1);
	assign ptr_inc   = ptr_q + CW'(1);
	assign out_free  = !m_valid_q || m_tready;
	assign in_mode   = status.mode == MODE_FADE_IN || status.mode == MODE_FLASH_IN;

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = m_valid_q;
	assign ptr      = ptr_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			ptr_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
			pass_q    <= 1'b0;
			pair_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_n;
			ptr_q     <= ptr_n;
			lo_q      <= lo_n;
			hi_q      <= hi_n;
			pass_q    <= pass_n;
			pair_q    <= pair_n;
			m_valid_q <= m_valid_n;
		end
	end

	always_comb begin
		state_n = state_q;
		ptr_n   = ptr_q;
		lo_n    = lo_q;
		hi_n    = hi_q;
		pass_n  = pass_q;
		pair_n  = pair_q;
		cmd     = '0;
		cmd.pass = pass_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					state_n  = ST_RESULT;
					case (func)
						FUNC_START: begin
							if (fade_kind == KIND_FADE_IN && !fin_empty) begin
								state_n = ST_SWEEP;
								ptr_n   = first_w;
								hi_n    = fin_hi;
							end else if (fade_kind == KIND_FLASH_IN) begin
								state_n = ST_SWEEP;
								ptr_n   = '0;
								hi_n    = ENTRIES_W;
							end
						end
						FUNC_TICK: begin
							pass_n = 1'b0;
							pair_n = !in_mode || status.pair_en;
							if (status.mode == MODE_FADE_IN) begin
								if (!fin_empty) begin
									state_n = ST_STEP;
									ptr_n   = first_w;
									lo_n    = first_w;
									hi_n    = fin_hi;
								end
							end else if (status.mode != MODE_NONE) begin
								state_n = ST_STEP;
								ptr_n   = '0;
								lo_n    = '0;
								hi_n    = ENTRIES_W;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SWEEP: begin
				cmd.fill_wr = 1'b1;
				ptr_n       = ptr_inc;
				if (ptr_inc == hi_q) state_n = ST_RESULT;
			end
			ST_STEP: begin
				cmd.step_rd = 1'b1;
				if (ptr_inc == hi_q) begin
					if (!pass_q && pair_q) begin
						pass_n = 1'b1;
						ptr_n  = lo_q;
					end else begin
						state_n = ST_RESULT;
					end
				end else begin
					ptr_n = ptr_inc;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		m_valid_n = m_valid_q;
		if (cmd.out_load) m_valid_n = 1'b1;
		else if (m_valid_q && m_tready) m_valid_n = 1'b0;
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(m_valid_q && !m_tready))
		else $error("Result loaded over a beat that was not taken.");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP || state_q == ST_SWEEP) |-> ptr_q < hi_q)
		else $error("Entry pointer ran past the end of the range.");

	a_item_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> state_q != ST_IDLE)
		else $error("Accepted beat produced no work.");

	a_sweep_mode: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> (status.mode == MODE_FADE_IN ||
			status.mode == MODE_FLASH_IN))
		else $error("Working bank fill outside an in-fade start.");

endmodule

[design/palette_fade_engine.sv]
// Palette fade engine top level. A write or read beat goes through the result state into
// the output register, which loads once any earlier result beat is taken. A start beat
// first fills working bank 1 (the fade-in range, or all ENTRIES for flash-in); a tick beat
// steps each entry through the single read-modify-write path of the palette memory.
// One beat is in work at a time; the next is taken while a result waits to be taken.
// arst_n resets mode, step count, configuration and handshake state; palette memory is
// undefined until written.
module palette_fade_engine import pfe_pkg::*; #(
	parameter int ENTRIES    = ENTRIES_DEF,
	parameter int FADE_TICKS = FADE_TICKS_DEF,
	parameter int LEVEL_STEP = LEVEL_STEP_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// bank[1:0], entry_index[7:2], red_in[15:8], green_in[23:16], blue_in[31:24],
	// fade_kind[33:32], zero fill above
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// func[1:0]
	input  logic [IN_USER_W-1:0]  s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// done_res[0], active[1], red_out[9:2], green_out[17:10], blue_out[25:18],
	// zero fill above
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pfe_cmd_t                   cmd;
	pfe_status_t                status;
	logic [$clog2(ENTRIES)-1:0] ptr;
	func_t                      func;
	kind_t                      fade_kind;

	assign func      = func_t'(s_tuser);
	assign fade_kind = kind_t'(s_tdata[33:32]);
	assign cfg_ready = 1'b1;

	pfe_ctrl #(
		.ENTRIES (ENTRIES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.func      (func),
		.fade_kind (fade_kind),
		.status    (status),
		.cmd       (cmd),
		.ptr       (ptr)
	);

	pfe_datapath #(
		.ENTRIES    (ENTRIES),
		.FADE_TICKS (FADE_TICKS),
		.LEVEL_STEP (LEVEL_STEP)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.ptr         (ptr),
		.status      (status),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.func        (func),
		.bank        (bank_t'(s_tdata[1:0])),
		.entry_index (s_tdata[7:2]),
		.red_in      (s_tdata[15:8]),
		.green_in    (s_tdata[23:16]),
		.blue_in     (s_tdata[31:24]),
		.fade_kind   (fade_kind),
		.m_tdata     (m_tdata)
	);

endmodule

[test/pfe_status_checker.sv]
// Status checker for the palette fade engine: watches the config, input and result channels.
// Keeps its own copy of the four palette banks, fade mode and step count, and compares each
// result beat with the oldest predicted status. Depends on pfe_pkg.
module pfe_status_checker import pfe_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [IN_USER_W-1:0]  s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    outstanding,
	output int                    errors
);

	localparam logic [7:0] STEP = 8'(LEVEL_STEP_DEF);

	typedef struct packed {
		logic done;
		logic active;
		rgb_t lvl;
	} fade_status_t;

	rgb_t         palette [4][ENTRIES_DEF];
	mode_t        mode;
	int           ticks_taken;
	logic [5:0]   first_entry;
	logic [5:0]   entry_span;
	logic         pair_two;
	fade_status_t owed_status [$];

	function automatic rgb_t nudge_level(input rgb_t d, input rgb_t t);
		rgb_t n;
		n = d;
		case (mode)
			MODE_FADE_IN: begin
				if (t.b > d.b) n.b = d.b + STEP;
				else if (t.g > d.g) n.g = d.g + STEP;
				else if (t.r > d.r) n.r = d.r + STEP;
			end
			MODE_FADE_OUT: begin
				if (d.r != 8'd0) n.r = d.r - STEP;
				else if (d.g != 8'd0) n.g = d.g - STEP;
				else if (d.b != 8'd0) n.b = d.b - STEP;
			end
			MODE_FLASH_IN: begin
				if (t.b < d.b) n.b = d.b - STEP;
				else if (t.g < d.g) n.g = d.g - STEP;
				else if (t.r < d.r) n.r = d.r - STEP;
			end
			default: begin
				if (d.r != WHITE_LEVEL) n.r = d.r + STEP;
				else if (d.g != WHITE_LEVEL) n.g = d.g + STEP;
				else if (d.b != WHITE_LEVEL) n.b = d.b + STEP;
			end
		endcase
		return n;
	endfunction

	// Only fade-in is limited to the configured window; the range is inclusive.
	task automatic fade_range(output int lo, output int hi);
		lo = 0;
		hi = ENTRIES_DEF - 1;
		if (mode == MODE_FADE_IN) begin
			lo = first_entry;
			hi = int'(first_entry) + int'(entry_span);
			if (hi > ENTRIES_DEF - 1) hi = ENTRIES_DEF - 1;
		end
	endtask

	task automatic sweep_bank(input bank_t work, input bank_t tgt);
		int lo, hi;
		fade_range(lo, hi);
		for (int i = lo; i <= hi; i++)
			palette[work][i] = nudge_level(palette[work][i], palette[tgt][i]);
	endtask

	task automatic advance_palette(input func_t f, input logic [IN_DATA_W-1:0] d,
			output fade_status_t st);
		bank_t      bk;
		logic [5:0] idx;
		int         lo, hi;
		bk = bank_t'(d[1:0]);
		idx = d[7:2];
		st = '0;
		case (f)
			FUNC_WRITE: begin
				palette[bk][idx] = {d[15:8], d[23:16], d[31:24]};
				st.done = (mode == MODE_NONE);
			end
			FUNC_READ: begin
				st.lvl = palette[bk][idx];
				st.done = (mode == MODE_NONE);
			end
			FUNC_START: begin
				mode = mode_t'({1'b0, d[33:32]} + 3'd1);
				ticks_taken = 0;
				fade_range(lo, hi);
				if (mode == MODE_FADE_IN || mode == MODE_FLASH_IN)
					for (int i = lo; i <= hi; i++)
						palette[BANK_WORK1][i] = (mode == MODE_FADE_IN) ? '0 : {3{WHITE_LEVEL}};
			end
			default: begin
				if (mode == MODE_NONE) begin
					st.done = 1'b1;
				end else begin
					sweep_bank(BANK_WORK1, BANK_TARGET1);
					if (pair_two || !(mode == MODE_FADE_IN || mode == MODE_FLASH_IN))
						sweep_bank(BANK_WORK2, BANK_TARGET2);
					ticks_taken++;
					if (ticks_taken >= FADE_TICKS_DEF) begin
						ticks_taken = 0;
						st.done = 1'b1;
					end
				end
			end
		endcase
		st.active = (mode != MODE_NONE);
	endtask

	task automatic log_mismatch(input string what, input fade_status_t want,
			input fade_status_t got);
		if (errors < 10)
			$display({"%0t %s: expected done=%0b active=%0b rgb=%02h_%02h_%02h,",
				" got done=%0b active=%0b rgb=%02h_%02h_%02h"},
				$time, what, want.done, want.active, want.lvl.r, want.lvl.g, want.lvl.b,
				got.done, got.active, got.lvl.r, got.lvl.g, got.lvl.b);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		fade_status_t want, got;
		if (!arst_n) begin
			mode = MODE_NONE;
			ticks_taken = 0;
			first_entry = 6'd0;
			entry_span = 6'd63;
			pair_two = 1'b1;
			errors = 0;
			for (int b = 0; b < 4; b++)
				for (int i = 0; i < ENTRIES_DEF; i++)
					palette[b][i] = '0;
			owed_status.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_FIRST_ENTRY: first_entry = cfg_data;
					CFG_ENTRY_SPAN:  entry_span = cfg_data;
					CFG_PAIR_TWO:    pair_two = cfg_data[0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				advance_palette(func_t'(s_tuser), s_tdata, want);
				owed_status.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.done = m_tdata[0];
				got.active = m_tdata[1];
				got.lvl.r = m_tdata[9:2];
				got.lvl.g = m_tdata[17:10];
				got.lvl.b = m_tdata[25:18];
				if (owed_status.size() == 0) begin
					log_mismatch("result beat with nothing expected", '0, got);
				end else begin
					want = owed_status.pop_front();
					if (got.done !== want.done || got.active !== want.active ||
							got.lvl.r !== want.lvl.r || got.lvl.g !== want.lvl.g ||
							got.lvl.b !== want.lvl.b)
						log_mismatch("status beat mismatch", want, got);
				end
			end
			outstanding <= owed_status.size();
		end
	end

endmodule

[test/tb_palette_fade_engine.sv]
// Top of the palette fade engine testbench: clock, reset, stimulus, result-side backpressure
// and the verdict. Instantiates palette_fade_engine and pfe_status_checker; uses pfe_pkg.
module tb_palette_fade_engine import pfe_pkg::*;;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [IN_USER_W-1:0]  s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	int                    outstanding;
	int                    errors;
	int                    gap_max = 5;
	int                    beats_sent = 0;

	always #5 clk = ~clk;

	palette_fade_engine i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pfe_status_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.outstanding(outstanding),
		.errors     (errors)
	);

	function automatic rgb_t any_level();
		rgb_t v;
		v = 24'($urandom);
		return v;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_item(input bank_t bk, input logic [5:0] idx,
			input rgb_t lvl, input kind_t kd);
		return {6'd0, kd, lvl.b, lvl.g, lvl.r, idx, bk};
	endfunction

	task automatic send_beat(input func_t f, input logic [IN_DATA_W-1:0] d);
		int gap;
		gap = $urandom_range(0, gap_max);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= f;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	task automatic put_entry(input bank_t bk, input logic [5:0] idx, input rgb_t lvl);
		send_beat(FUNC_WRITE, pack_item(bk, idx, lvl, kind_t'($urandom_range(0, 3))));
	endtask

	task automatic get_entry(input bank_t bk, input logic [5:0] idx);
		send_beat(FUNC_READ, pack_item(bk, idx, any_level(), kind_t'($urandom_range(0, 3))));
	endtask

	task automatic begin_fade(input kind_t kd);
		send_beat(FUNC_START, pack_item(bank_t'($urandom_range(0, 3)),
			6'($urandom_range(0, 63)), any_level(), kd));
	endtask

	task automatic frame_tick();
		send_beat(FUNC_TICK, pack_item(bank_t'($urandom_range(0, 3)),
			6'($urandom_range(0, 63)), any_level(), kind_t'($urandom_range(0, 3))));
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t ri, input logic [CFG_DATA_W-1:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [5:0] first, input logic [5:0] span,
			input logic pair);
		write_reg(CFG_FIRST_ENTRY, first);
		write_reg(CFG_ENTRY_SPAN, span);
		write_reg(CFG_PAIR_TWO, {5'd0, pair});
	endtask

	// Result side: random stalls per beat, quiet stretches, and one long hold-off so the
	// engine backs up into its input.
	initial begin
		int wait_cycles, taken, stall_max;
		taken = 0;
		stall_max = 5;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0) stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
			wait_cycles = (taken == 400) ? 400 : $urandom_range(0, stall_max);
			repeat (wait_cycles) begin
				m_tready <= 1'b0;
				@(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			taken++;
		end
	end

	initial begin
		#20000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int phase, ticks, pick;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_settings(6'd0, 6'd63, 1'b1);

		// Every entry of every bank is written before anything reads or steps it.
		for (int b = 0; b < 4; b++)
			for (int e = 0; e < ENTRIES_DEF; e++)
				put_entry(bank_t'(b), 6'(e), (e == 0) ? 24'h000000 :
					(e == ENTRIES_DEF - 1) ? 24'hFFFFFF : any_level());

		frame_tick();
		get_entry(BANK_WORK1, 6'd0);
		get_entry(BANK_TARGET2, 6'd63);
		put_entry(BANK_WORK1, 6'd5, {8'h10, 8'hFF, 8'h00});
		begin_fade(KIND_FADE_OUT);
		frame_tick();
		get_entry(BANK_WORK1, 6'd5);
		begin_fade(KIND_FLASH_OUT);
		frame_tick();
		get_entry(BANK_WORK2, 6'd63);
		begin_fade(KIND_FLASH_IN);
		frame_tick();
		get_entry(BANK_WORK1, 6'd63);
		begin_fade(KIND_FADE_IN);
		frame_tick();
		get_entry(BANK_WORK1, 6'd0);
		put_entry(BANK_TARGET1, 6'd63, 24'hFFFFFF);
		put_entry(BANK_WORK1, 6'd0, 24'h000000);
		get_entry(BANK_TARGET1, 6'd63);

		phase = 0;
		while (beats_sent < 1400) begin
			if (phase % 3 == 0) begin
				settle();
				case (phase / 3)
					0: load_settings(6'd0, 6'd63, 1'b0);
					1: load_settings(6'd63, 6'd63, 1'b1);
					2: load_settings(6'd0, 6'd0, 1'b0);
					3: load_settings(6'd63, 6'd0, 1'b1);
					default: load_settings(6'($urandom_range(0, 63)),
						6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
				endcase
			end
			gap_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			if ($urandom_range(0, 4) == 0) begin
				repeat (20)
					send_beat(func_t'($urandom_range(0, 3)),
						pack_item(bank_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
							any_level(), kind_t'($urandom_range(0, 3))));
			end else begin
				begin_fade(kind_t'($urandom_range(0, 3)));
				ticks = $urandom_range(20, 26);
				while (ticks > 0) begin
					pick = $urandom_range(0, 9);
					if (pick < 3) begin
						get_entry(bank_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)));
					end else if (pick == 3) begin
						put_entry(bank_t'($urandom_range(0, 3)), 6'($urandom_range(0, 63)),
							any_level());
					end else begin
						frame_tick();
						ticks--;
					end
				end
			end
			phase++;
		end

		settle();
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
